// ===== hw/rtl/ostt_pkg.sv =====
// Shared types, codes and sizes for the one-shot timer slot table.
// No dependencies; compile first.
package ostt_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    localparam int MODE_W   = 2;
    localparam int TIME_W   = 32;
    localparam int TAG_W    = 16;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 4;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADD_REJECTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CANCELLED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CANCEL_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIRED          = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTHING_DUE    = 3'd5;

    // One timer slot as it travels along the chain
    typedef struct packed {
        logic              active;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] due;
    } entry_t;

    // Latched request
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [TIME_W-1:0]         now;
        logic [TIME_W-1:0]         delay;
        logic [TAG_W-1:0]          tag;
        logic signed [INDEX_W-1:0] slot_index;
    } req_t;

    // Decision of the head for the slot under it
    typedef struct packed {
        logic add;
        logic free;
        logic fire;
    } hit_t;

    // One result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [TAG_W-1:0]    fired_tag;
        logic [COUNT_W-1:0]  active_count;
        logic                last;
    } result_t;

endpackage

// ===== hw/rtl/ostt_item_if.sv =====
// Request and result channel interfaces (valid/ready with payload).
// Depends on ostt_pkg.
interface ostt_item_if;
    import ostt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [TIME_W-1:0]         now;
    logic [TIME_W-1:0]         delay;
    logic [TAG_W-1:0]          tag;
    logic signed [INDEX_W-1:0] slot_index;

    modport source (output valid, mode, now, delay, tag, slot_index, input ready);
    modport sink   (input valid, mode, now, delay, tag, slot_index, output ready);
endinterface

interface ostt_result_if;
    import ostt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TAG_W-1:0]    fired_tag;
    logic [COUNT_W-1:0]  active_count;
    logic                last;

    modport source (output valid, status, slot, fired_tag, active_count, last, input ready);
    modport sink   (input valid, status, slot, fired_tag, active_count, last, output ready);
endinterface

// ===== hw/rtl/ostt_cell.sv =====
// One storage cell of the timer chain: holds a slot, takes its neighbor's on shift.
// Depends on ostt_pkg.
module ostt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  ostt_pkg::entry_t d,
    output ostt_pkg::entry_t q
);
    import ostt_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule

// ===== hw/rtl/ostt_head.sv =====
// Head of the timer chain: decides add, cancel or fire for the slot at cell 0
// and forms the entry that re-enters the far end. Depends on ostt_pkg.
module ostt_head #(
    parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
    input  ostt_pkg::entry_t               cur,
    input  ostt_pkg::req_t                 req,
    input  logic [$clog2(SLOTS+1)-1:0]     step,
    input  logic [$clog2(SLOTS+1)-1:0]     count,
    input  logic [ostt_pkg::FIRE_W-1:0]    fired,
    input  logic                           found,
    output ostt_pkg::entry_t               upd,
    output ostt_pkg::hit_t                 hit
);
    import ostt_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    logic [TIME_W-1:0] lag;
    logic              add_ok;
    logic              cancel_ok;
    logic              fire_ok;

    always_comb
    begin
        // wrap-aware: due when now - due is not negative
        lag       = req.now - cur.due;
        add_ok    = (req.mode == MODE_ADD) && (req.tag != '0) &&
                    (count < CW'(SLOTS)) && !found && !cur.active;
        cancel_ok = (req.mode == MODE_CANCEL) && !req.slot_index[INDEX_W-1] &&
                    (7'(req.slot_index[INDEX_W-2:0]) == 7'(step)) && cur.active;
        fire_ok   = (req.mode == MODE_TICK) && cur.active && !lag[TIME_W-1] &&
                    (fired < FIRE_W'(MAX_RESULTS));

        upd = cur;
        if (add_ok)
        begin
            upd.active = 1'b1;
            upd.tag    = req.tag;
            upd.due    = req.now + req.delay;
        end
        else if (cancel_ok || fire_ok)
        begin
            // freed slots keep their due time
            upd.active = 1'b0;
            upd.tag    = '0;
        end

        hit.add  = add_ok;
        hit.free = cancel_ok || fire_ok;
        hit.fire = fire_ok;
    end
endmodule

// ===== hw/rtl/one_shot_timer_slot_table.sv =====
// One-shot timer slot table. A request is taken while idle, then the slots rotate past
// the head one per cycle while no fired result stalls them, and the closing result is
// loaded after the scan; no new request is taken until that result is loaded.
// The head compares and updates each slot on the rotating chain. Fired results stall
// the rotation while the output register is full. Reset clears every slot and the count.
module one_shot_timer_slot_table #(
    parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ostt_item_if.sink     item,
    ostt_result_if.source result
);
    import ostt_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    req_t              req_reg;
    logic [CW-1:0]     step_reg, step_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [FIRE_W-1:0] fired_reg, fired_next;
    // most recent hit: its slot and tag, held until the next hit or the start of the next scan
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    entry_t            cell_q [SLOTS];
    entry_t            head_upd;
    hit_t              hit;
    logic              shift;
    logic              accept;
    logic              out_free;
    logic              push;
    logic              out_load;

    // Chain: cell k takes cell k+1, the last cell takes the head's updated entry.
    // After SLOTS shifts every slot is back in its own cell.
    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_cell
            if (k == SLOTS - 1)
            begin : g_tail
                ostt_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (head_upd),
                    .q     (cell_q[k])
                );
            end
            else
            begin : g_mid
                ostt_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (cell_q[k+1]),
                    .q     (cell_q[k])
                );
            end
        end
    endgenerate

    ostt_head #(.SLOTS(SLOTS)) u_head (
        .cur   (cell_q[0]),
        .req   (req_reg),
        .step  (step_reg),
        .count (count_reg),
        .fired (fired_reg),
        .found (pend_valid_reg),
        .upd   (head_upd),
        .hit   (hit)
    );

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    // a new fire pushes the previous one out with last low
    assign push     = (state_reg == ST_SCAN) && hit.fire && pend_valid_reg;
    assign shift    = (state_reg == ST_SCAN) && (!push || out_free);
    assign out_load = (push && out_free) || ((state_reg == ST_FINISH) && out_free);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        fired_next      = fired_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.mode != MODE_NONE))
                begin
                    state_next      = ST_SCAN;
                    step_next       = '0;
                    fired_next      = '0;
                    pend_valid_next = 1'b0;
                    pend_slot_next  = '0;
                    pend_tag_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (shift)
                begin
                    if (hit.add)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (hit.free)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    if (hit.fire)
                    begin
                        fired_next = fired_reg + 1'b1;
                    end
                    if (hit.add || hit.free)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = SLOT_W'(step_reg);
                        pend_tag_next   = cell_q[0].tag;
                    end
                    if (step_reg == CW'(SLOTS - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result formation: a pushed fire during the scan, or the closing result
    always_comb
    begin
        out_next              = out_reg;
        out_valid_next        = out_valid_reg && !result.ready;
        out_next.active_count = COUNT_W'(count_reg);
        out_next.slot         = pend_valid_reg ? pend_slot_reg : '0;
        out_next.fired_tag    = '0;
        out_next.last         = 1'b1;
        out_next.status       = ST_NOTHING_DUE;
        if (push)
        begin
            out_next.status    = ST_FIRED;
            out_next.fired_tag = pend_tag_reg;
            out_next.last      = 1'b0;
        end
        else
        begin
            case (req_reg.mode)
                MODE_ADD:
                begin
                    out_next.status = pend_valid_reg ? ST_ADDED : ST_ADD_REJECTED;
                end
                MODE_CANCEL:
                begin
                    out_next.status = pend_valid_reg ? ST_CANCELLED : ST_CANCEL_IGNORED;
                end
                default:
                begin
                    out_next.status    = pend_valid_reg ? ST_FIRED : ST_NOTHING_DUE;
                    out_next.fired_tag = pend_valid_reg ? pend_tag_reg : '0;
                end
            endcase
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            count_reg      <= '0;
            fired_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            fired_reg      <= fired_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        if (accept)
        begin
            req_reg.mode       <= item.mode;
            req_reg.now        <= item.now;
            req_reg.delay      <= item.delay;
            req_reg.tag        <= item.tag;
            req_reg.slot_index <= item.slot_index;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign item.ready          = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.status       = out_reg.status;
    assign result.slot         = out_reg.slot;
    assign result.fired_tag    = out_reg.fired_tag;
    assign result.active_count = out_reg.active_count;
    assign result.last         = out_reg.last;

    // Count never runs past the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("active count exceeds slot count");

    // Fires per tick stay within the result limit
    a_fired_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fired_reg <= FIRE_W'(MAX_RESULTS))
        else $error("too many fires in one tick");

    // A closing result that leaves FINISH is shown next cycle with last set
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_free |=> result.valid && result.last)
        else $error("closing result missing or without last");

    // A request of a real mode starts a scan
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.mode != MODE_NONE) |=> (state_reg == ST_SCAN) && (step_reg == '0))
        else $error("request did not start a scan");
endmodule

// ===== verif/tb_one_shot_timer_slot_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for one_shot_timer_slot_table: a directed request table, then random
// request traffic under several idle/stall mixes, scored against typed rows or a local model.
// Depends on ostt_pkg, ostt_item_if, ostt_result_if and the one_shot_timer_slot_table RTL.
module tb_one_shot_timer_slot_table;
    import ostt_pkg::*;

    localparam int SLOTS           = SLOTS_DEF;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_ITEMS    = 288;
    localparam int NUM_PHASES      = 5;
    localparam int NUM_DIRECTED    = 23;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_POINT     = 20;
    // Watch time after the drain, scaled with the slot count.
    localparam int TAIL_CYCLES     = 4 * (SLOTS + 2);
    localparam int MAX_REPORTS     = 60;
    localparam int RUN_LIMIT_NS    = 8_000_000;

    // Idle percentages per random phase: clean, sender idle, receiver stall, both, clean.
    localparam int PHASE_TX_IDLE  [NUM_PHASES] = '{0, 87, 0, 17, 0};
    localparam int PHASE_RX_STALL [NUM_PHASES] = '{0, 0, 87, 17, 0};

    localparam logic [TIME_W-1:0] T_MAX  = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] T_HALF = 32'h8000_0000;

    // One row of the directed table. With typed clear, status/slot/count are don't-care and
    // the local model supplies the expectation.
    typedef struct packed {
        req_t    req;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ostt_item_if   item_ch ();
    ostt_result_if result_ch ();

    one_shot_timer_slot_table #(
        .SLOTS (SLOTS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Local timer table: mirrors the block's slots, tags and live bits.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] tbl_due  [SLOTS];
    logic [TAG_W-1:0]  tbl_tag  [SLOTS];
    logic              tbl_live [SLOTS];
    int                tbl_count;

    // Results still owed by the block, oldest first.
    result_t pending_results [$];

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int rx_hold_cycles = 0;
    int fail_count     = 0;

    stim_row_t directed [NUM_DIRECTED];

    function automatic stim_row_t dir_row(logic [MODE_W-1:0] mode, logic [TIME_W-1:0] now,
                                          logic [TIME_W-1:0] delay, logic [TAG_W-1:0] tag,
                                          logic signed [INDEX_W-1:0] idx, logic typed,
                                          logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] slot,
                                          logic [COUNT_W-1:0] cnt);
        stim_row_t r;
        r.req   = '{mode: mode, now: now, delay: delay, tag: tag, slot_index: idx};
        r.typed = typed;
        r.want  = '{status: st, slot: slot, fired_tag: '0, active_count: cnt, last: 1'b1};
        return r;
    endfunction

    // Build one result with the current live count, as the block reports it.
    function automatic result_t tbl_result(logic [STATUS_W-1:0] st, int slot,
                                           logic [TAG_W-1:0] tag, logic last);
        result_t r;
        r.status       = st;
        r.slot         = slot[SLOT_W-1:0];
        r.fired_tag    = tag;
        r.active_count = tbl_count[COUNT_W-1:0];
        r.last         = last;
        return r;
    endfunction

    // Free a slot: drop the tag, keep the due time.
    function automatic void tbl_release(int i);
        tbl_live[i] = 1'b0;
        tbl_tag[i]  = '0;
        if (tbl_count > 0)
            tbl_count--;
    endfunction

    // Apply one accepted request to the local table and list the results it causes.
    function automatic void timer_table_apply(input req_t r, ref result_t outs[$]);
        logic [TIME_W-1:0] age;
        logic [TAG_W-1:0]  fired;
        int                slot_no;
        int                idx;
        int                n;
        outs.delete();
        case (r.mode)
            MODE_ADD:
            begin
                slot_no = -1;
                if (r.tag != '0 && tbl_count < SLOTS)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!tbl_live[i])
                            slot_no = i;
                if (slot_no < 0)
                    outs.push_back(tbl_result(ST_ADD_REJECTED, 0, '0, 1'b1));
                else
                begin
                    tbl_due[slot_no]  = r.now + r.delay;
                    tbl_tag[slot_no]  = r.tag;
                    tbl_live[slot_no] = 1'b1;
                    tbl_count++;
                    outs.push_back(tbl_result(ST_ADDED, slot_no, '0, 1'b1));
                end
            end
            MODE_CANCEL:
            begin
                idx = int'(r.slot_index);
                if (idx >= 0 && idx < SLOTS && tbl_live[idx])
                begin
                    tbl_release(idx);
                    outs.push_back(tbl_result(ST_CANCELLED, idx, '0, 1'b1));
                end
                else
                    outs.push_back(tbl_result(ST_CANCEL_IGNORED, 0, '0, 1'b1));
            end
            MODE_TICK:
            begin
                n = 0;
                for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++)
                begin
                    if (tbl_live[i])
                    begin
                        // Wrap-aware: due when now - due reads as non-negative.
                        age = r.now - tbl_due[i];
                        if (!age[TIME_W-1])
                        begin
                            fired = tbl_tag[i];
                            tbl_release(i);
                            outs.push_back(tbl_result(ST_FIRED, i, fired, 1'b0));
                            n++;
                        end
                    end
                end
                if (n == 0)
                    outs.push_back(tbl_result(ST_NOTHING_DUE, 0, '0, 1'b1));
                else
                    outs[outs.size() - 1].last = 1'b1;
            end
            default:
            begin
                // Unused mode: no result, table untouched.
            end
        endcase
    endfunction

    // Offer one request, wait for the handshake, then record what it owes.
    // Valid is only lowered when an idle cycle is chosen, so back-to-back requests keep it high.
    task automatic issue_request(input req_t r, input logic typed, input result_t want);
        result_t outs [$];
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= r.mode;
        item_ch.now        <= r.now;
        item_ch.delay      <= r.delay;
        item_ch.tag        <= r.tag;
        item_ch.slot_index <= r.slot_index;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        timer_table_apply(r, outs);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (outs[k])
                pending_results.push_back(outs[k]);
    endtask

    // ------------------------------------------------------------------
    // Result side: score each accepted result, then pick the next ready.
    // A requested hold-off is counted down here, one cycle per edge.
    // ------------------------------------------------------------------
    initial
    begin
        result_t got;
        result_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got = '{status: result_ch.status, slot: result_ch.slot,
                        fired_tag: result_ch.fired_tag, active_count: result_ch.active_count,
                        last: result_ch.last};
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %p", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.fired_tag !== want.fired_tag ||
                        got.active_count !== want.active_count || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (rx_hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side: reset, directed table, random phases, drain.
    // ------------------------------------------------------------------
    initial
    begin
        req_t              rq;
        result_t           no_want;
        logic [TIME_W-1:0] sim_ms;
        int                issued;
        int                pick;
        bit                drained_once;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= MODE_TICK;
        item_ch.now        <= '0;
        item_ch.delay      <= '0;
        item_ch.tag        <= '0;
        item_ch.slot_index <= '0;
        no_want      = '0;
        drained_once = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_due[i]  = '0;
            tbl_tag[i]  = '0;
            tbl_live[i] = 1'b0;
        end
        tbl_count = 0;

        // Directed table. Typed rows carry the expectation read straight off the spec:
        // empty table after reset, zero tag, full table, bad cancel indexes, wrap extremes.
        directed = '{
            // Tick on an empty table: nothing due.
            dir_row(MODE_TICK,   '0,     '0,     '0,       8'sd0,   1'b1, ST_NOTHING_DUE,    0, 0),
            // Cancel of an inactive slot.
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sd0,   1'b1, ST_CANCEL_IGNORED, 0, 0),
            // Add with zero tag is rejected.
            dir_row(MODE_ADD,    T_MAX,  T_MAX,  16'h0000, 8'sd0,   1'b1, ST_ADD_REJECTED,   0, 0),
            // Fill every slot; due times straddle the wrap and the sign boundary.
            dir_row(MODE_ADD,    T_MAX,  32'd1,  16'hFFFF, 8'sd0,   1'b1, ST_ADDED,          0, 1),
            dir_row(MODE_ADD,    '0,     T_MAX,  16'h0001, 8'sd0,   1'b1, ST_ADDED,          1, 2),
            dir_row(MODE_ADD,    T_HALF, '0,     16'h8000, 8'sd0,   1'b1, ST_ADDED,          2, 3),
            dir_row(MODE_ADD,    '0,     ~T_HALF, 16'hAAAA, 8'sd0,  1'b1, ST_ADDED,          3, 4),
            dir_row(MODE_ADD,    32'h1234_5678, '0, 16'h5555, 8'sd0, 1'b1, ST_ADDED,         4, 5),
            dir_row(MODE_ADD,    '0,     32'd100, 16'h0100, 8'sd0,  1'b1, ST_ADDED,          5, 6),
            dir_row(MODE_ADD,    '0,     '0,     16'h0002, 8'sd0,   1'b1, ST_ADDED,          6, 7),
            dir_row(MODE_ADD,    '0,     T_HALF, 16'h0003, 8'sd0,   1'b1, ST_ADDED,          7, 8),
            // Full table rejects a valid add.
            dir_row(MODE_ADD,    '0,     '0,     16'h0004, 8'sd0,   1'b1, ST_ADD_REJECTED,   0, 8),
            // Negative and out-of-range cancels do nothing.
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sh80,  1'b1, ST_CANCEL_IGNORED, 0, 8),
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sh7F,  1'b1, ST_CANCEL_IGNORED, 0, 8),
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sd8,   1'b1, ST_CANCEL_IGNORED, 0, 8),
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'shFF,  1'b1, ST_CANCEL_IGNORED, 0, 8),
            // Cancel a live slot, then the same slot again.
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sd3,   1'b1, ST_CANCELLED,      3, 7),
            dir_row(MODE_CANCEL, '0,     '0,     '0,       8'sd3,   1'b1, ST_CANCEL_IGNORED, 0, 7),
            // Unused mode with every field set: no result.
            dir_row(MODE_NONE,   T_MAX,  T_MAX,  16'hFFFF, 8'shFF,  1'b0, ST_FIRED,          0, 0),
            // Ticks across the wrap: the model sorts out which slots fire.
            dir_row(MODE_TICK,   '0,     T_MAX,  16'hFFFF, 8'shFF,  1'b0, ST_FIRED,          0, 0),
            dir_row(MODE_TICK,   ~T_HALF, '0,    '0,       8'sd0,   1'b0, ST_FIRED,          0, 0),
            dir_row(MODE_TICK,   T_MAX,  '0,     '0,       8'sd0,   1'b0, ST_FIRED,          0, 0),
            // Table empty again.
            dir_row(MODE_TICK,   T_MAX,  '0,     '0,       8'sd0,   1'b1, ST_NOTHING_DUE,    0, 0)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            issue_request(directed[k].req, directed[k].typed, directed[k].want);

        // Random traffic. Keep a running millisecond clock that starts just below the wrap,
        // so adds and ticks mostly follow it and timers really come due. A few requests
        // use fully random times and indexes to cover the noise.
        sim_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            tx_idle_pct  = PHASE_TX_IDLE[phase];
            rx_stall_pct = PHASE_RX_STALL[phase];
            // Hold the receiver off while requests keep coming, so the block backs up.
            if (phase == 0)
                rx_hold_cycles = HOLD_OFF_CYCLES;
            issued = 0;
            while (issued < RANDOM_ITEMS / NUM_PHASES)
            begin
                // Once, stop offering until every owed result is back.
                if (phase == 2 && issued >= DRAIN_POINT && !drained_once)
                begin
                    item_ch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_results.size() != 0);
                    drained_once = 1'b1;
                end
                rq.now        = $urandom;
                rq.delay      = $urandom;
                rq.tag        = TAG_W'($urandom);
                rq.slot_index = INDEX_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    // Burst: fill the table with near-due timers, then one tick fires them all.
                    for (int b = 0; b < SLOTS; b++)
                    begin
                        rq.mode  = MODE_ADD;
                        rq.now   = sim_ms;
                        rq.delay = $urandom_range(0, 3);
                        rq.tag   = TAG_W'($urandom_range(1, 65535));
                        issue_request(rq, 1'b0, no_want);
                        issued++;
                    end
                    sim_ms  = sim_ms + 4;
                    rq.mode = MODE_TICK;
                    rq.now  = sim_ms;
                end
                else if (pick < 42)
                begin
                    rq.mode = MODE_ADD;
                    rq.now  = sim_ms;
                    if ($urandom_range(0, 9) != 0)
                        rq.delay = $urandom_range(0, 60);
                    if ($urandom_range(0, 19) == 0)
                        rq.tag = '0;
                    else
                        rq.tag = TAG_W'($urandom_range(1, 65535));
                end
                else if (pick < 70)
                begin
                    rq.mode = MODE_TICK;
                    sim_ms  = sim_ms + $urandom_range(0, 25);
                    if ($urandom_range(0, 14) != 0)
                        rq.now = sim_ms;
                end
                else if (pick < 94)
                begin
                    rq.mode = MODE_CANCEL;
                    if ($urandom_range(0, 4) != 0)
                        rq.slot_index = INDEX_W'($urandom_range(0, SLOTS - 1));
                end
                else
                    rq.mode = MODE_NONE;
                issue_request(rq, 1'b0, no_want);
                if (rq.mode != MODE_NONE)
                    issued++;
            end
        end

        // Stop offering, drain what is owed, then watch for stray results a while longer.
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
